// File: hdl/clf_pkg.sv
`timescale 1ns / 1ps

package clf_pkg;

	// Sample and field widths.
	localparam int SAMPLE_BITS = 10;
	localparam int OP_W        = 2;
	localparam int DRIVE_W     = 7;
	localparam int BASE_W      = 7;

	// Calibration state is held signed, one bit wider than a sample.
	localparam int ST_W   = SAMPLE_BITS + 1;
	// Differences and sums of two state values.
	localparam int DIFF_W = SAMPLE_BITS + 2;
	// Product of a difference and the gain of 200 (gain fits in 8 bits).
	localparam int PROD_W = DIFF_W + 8;
	// Magnitude of the dividend, which is also the number of divider steps.
	localparam int MAG_W  = PROD_W - 1;
	// Magnitude of the divisor.
	localparam int DVS_W  = DIFF_W - 1;
	// Step counter of the divider.
	localparam int CNT_W  = $clog2(MAG_W + 1);
	// Base power plus or minus the quotient.
	localparam int SUM_W  = PROD_W + 1;

	localparam int DRIVE_MAX  = 100;
	localparam int LOW_RESET  = 999;
	localparam int HIGH_RESET = -1;
	localparam int BASE_RESET = 100;

	// Opcodes of an input word.
	localparam logic [OP_W-1:0] OP_CAL    = 2'd0;
	localparam logic [OP_W-1:0] OP_LATCH  = 2'd1;
	localparam logic [OP_W-1:0] OP_FOLLOW = 2'd2;

	// Register port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	// Register index is the word address bit.
	localparam logic REG_BASE_POWER = 1'b0;

endpackage

// File: hdl/clf_if.sv
`timescale 1ns / 1ps

// Input channel: one opcode and one light sample per word.
interface clf_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [clf_pkg::OP_W-1:0]        opcode;
	logic [clf_pkg::SAMPLE_BITS-1:0] sample;

	modport source (output valid, output opcode, output sample, input ready);
	modport sink (input valid, input opcode, input sample, output ready);
endinterface

// Output channel: motor drives and status flags per word.
interface clf_res_if;
	logic                        valid;
	logic                        ready;
	logic [clf_pkg::DRIVE_W-1:0] right_drive;
	logic [clf_pkg::DRIVE_W-1:0] left_drive;
	logic                        above_threshold;
	logic                        span_error;

	modport source (output valid, output right_drive, output left_drive,
		output above_threshold, output span_error, input ready);
	modport sink (input valid, input right_drive, input left_drive,
		input above_threshold, input span_error, output ready);
endinterface

// File: hdl/calibrated_line_follow_steer.sv
`timescale 1ns / 1ps

// Proportional line follower with min/max light calibration.
// The cmd channel takes one word per item: an opcode and a light sample.
// Calibrate words track the largest sample, else the smallest; a latch word
// sets the threshold to the mean of the two; a follow word produces the
// steering drives base_power +/- 200*(threshold-sample)/(max-min), clamped
// to 0..100. Every accepted word yields exactly one word on the result
// channel. base_power is written through the APB port at byte address 0.
// Calibrate, latch and zero-span follow words (zero drives, span_error
// set) go from idle straight to the finish state; other follow words
// first pass the divide state: 19 steps of the shift-subtract divider,
// one quotient bit per step, then the finish state clamps and loads the
// output register. cmd.ready is high only while the sequencer is idle, so
// a new word is taken no sooner than the cycle after the result is loaded.
// The output register decouples the two sides: a new word is accepted while
// a finished result waits; if the receiver stalls, the next result is held
// in the sequencer until the output register frees up.
// Reset clears the calibration (minimum 999, maximum -1, threshold 0), sets
// base_power to 100 and empties the output register.
module calibrated_line_follow_steer (
	input  logic                           clk,
	input  logic                           arst_n,
	clf_cmd_if.sink                        cmd,
	clf_res_if.source                      result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [clf_pkg::PADDR_W-1:0]    paddr,
	input  logic [clf_pkg::PDATA_W-1:0]    pwdata,
	output logic [clf_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DIV    = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	localparam int ST_W   = clf_pkg::ST_W;
	localparam int DIFF_W = clf_pkg::DIFF_W;
	localparam int PROD_W = clf_pkg::PROD_W;
	localparam int MAG_W  = clf_pkg::MAG_W;
	localparam int DVS_W  = clf_pkg::DVS_W;
	localparam int CNT_W  = clf_pkg::CNT_W;
	localparam int SUM_W  = clf_pkg::SUM_W;
	localparam int DRV_W  = clf_pkg::DRIVE_W;

	logic [1:0] state_q;

	// Architectural state.
	logic signed [ST_W-1:0]          low_q;
	logic signed [ST_W-1:0]          high_q;
	logic signed [ST_W-1:0]          thr_q;
	logic [clf_pkg::BASE_W-1:0]      base_q;

	// Item in flight.
	logic              above_q;
	logic              err_q;
	logic              follow_q;
	logic              neg_q;
	logic [MAG_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [CNT_W-1:0]  cnt_q;

	// Output register.
	logic              out_valid_q;
	logic [DRV_W-1:0]  out_right_q;
	logic [DRV_W-1:0]  out_left_q;
	logic              out_above_q;
	logic              out_err_q;

	logic                     accept;
	logic                     cfg_write;
	logic                     out_free;
	logic signed [ST_W-1:0]   s_ext;
	logic                     above;
	logic signed [DIFF_W-1:0] sum_ls;
	logic signed [DIFF_W-1:0] half_ls;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_abs;
	logic signed [DIFF_W-1:0] span;
	logic signed [DIFF_W-1:0] span_abs;
	logic                     span_zero;
	logic [DVS_W:0]           shifted;
	logic [DVS_W+1:0]         trial;
	logic                     borrow;
	logic signed [PROD_W-1:0] quot;
	logic signed [SUM_W-1:0]  base_ext;
	logic signed [SUM_W-1:0]  quot_ext;
	logic signed [SUM_W-1:0]  right_sum;
	logic signed [SUM_W-1:0]  left_sum;
	logic [DRV_W-1:0]         right_cl;
	logic [DRV_W-1:0]         left_cl;

	// Saturate a drive sum to the motor range.
	function automatic logic [clf_pkg::DRIVE_W-1:0] clamp_drive(
		input logic signed [clf_pkg::SUM_W-1:0] v);
		logic [clf_pkg::DRIVE_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > clf_pkg::SUM_W'(clf_pkg::DRIVE_MAX)) begin
			r = clf_pkg::DRIVE_W'(clf_pkg::DRIVE_MAX);
		end else begin
			r = v[clf_pkg::DRIVE_W-1:0];
		end
		return r;
	endfunction

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || result.ready;

	// Register port: always ready, single register at word 0.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == clf_pkg::REG_BASE_POWER);
	assign prdata    = (paddr[2] == clf_pkg::REG_BASE_POWER) ?
		clf_pkg::PDATA_W'(base_q) : '0;

	// Compare, mean and dividend setup for the incoming word.
	always_comb begin
		s_ext     = signed'({1'b0, cmd.sample});
		above     = (cmd.opcode != clf_pkg::OP_LATCH) && (s_ext > thr_q);
		sum_ls    = DIFF_W'(low_q) + DIFF_W'(high_q);
		half_ls   = (sum_ls < 0) ? ((sum_ls + DIFF_W'(1)) >>> 1) : (sum_ls >>> 1);
		diff      = DIFF_W'(thr_q) - DIFF_W'(s_ext);
		prod      = (PROD_W'(diff) <<< 7) + (PROD_W'(diff) <<< 6) + (PROD_W'(diff) <<< 3);
		prod_abs  = prod[PROD_W-1] ? -prod : prod;
		span      = DIFF_W'(high_q) - DIFF_W'(low_q);
		span_abs  = span[DIFF_W-1] ? -span : span;
		span_zero = (span == '0);
	end

	// One restoring-division step.
	always_comb begin
		shifted = {rem_q, dvd_q[MAG_W-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
		borrow  = trial[DVS_W+1];
	end

	// Apply the sign, add to base power and clamp.
	always_comb begin
		quot      = neg_q ? -signed'({1'b0, dvd_q}) : signed'({1'b0, dvd_q});
		base_ext  = signed'(SUM_W'(base_q));
		quot_ext  = SUM_W'(quot);
		right_sum = base_ext + quot_ext;
		left_sum  = base_ext - quot_ext;
		right_cl  = clamp_drive(right_sum);
		left_cl   = clamp_drive(left_sum);
	end

	// Sequencer, calibration state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			low_q       <= ST_W'(clf_pkg::LOW_RESET);
			high_q      <= ST_W'(clf_pkg::HIGH_RESET);
			thr_q       <= '0;
			base_q      <= clf_pkg::BASE_W'(clf_pkg::BASE_RESET);
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_write) begin
				base_q <= pwdata[clf_pkg::BASE_W-1:0];
			end
			// A finished item fills the output register; an accepted word empties it.
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.opcode == clf_pkg::OP_CAL) begin
							if (s_ext > high_q) begin
								high_q <= s_ext;
							end else if (s_ext < low_q) begin
								low_q <= s_ext;
							end
						end
						if (cmd.opcode == clf_pkg::OP_LATCH) begin
							thr_q <= half_ls[ST_W-1:0];
						end
						cnt_q <= CNT_W'(MAG_W - 1);
						if (cmd.opcode == clf_pkg::OP_FOLLOW && !span_zero) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the item in flight and the output word.
	always_ff @(posedge clk) begin
		if (accept) begin
			above_q  <= above;
			err_q    <= (cmd.opcode == clf_pkg::OP_FOLLOW) && span_zero;
			follow_q <= (cmd.opcode == clf_pkg::OP_FOLLOW) && !span_zero;
			neg_q    <= prod[PROD_W-1] ^ span[DIFF_W-1];
			dvd_q    <= prod_abs[MAG_W-1:0];
			dvs_q    <= span_abs[DVS_W-1:0];
			rem_q    <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[MAG_W-2:0], !borrow};
			rem_q <= borrow ? shifted[DVS_W-1:0] : trial[DVS_W-1:0];
		end
		if (state_q == ST_FINISH && out_free) begin
			out_right_q <= follow_q ? right_cl : '0;
			out_left_q  <= follow_q ? left_cl : '0;
			out_above_q <= above_q;
			out_err_q   <= err_q;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.right_drive     = out_right_q;
	assign result.left_drive      = out_left_q;
	assign result.above_threshold = out_above_q;
	assign result.span_error      = out_err_q;

endmodule

// File: hdl/clf_checker.sv
`timescale 1ns / 1ps

module clf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [clf_pkg::DRIVE_W-1:0]   right_drive,
	input logic [clf_pkg::DRIVE_W-1:0]   left_drive,
	input logic                          span_error
);

	// A stalled result word holds its place.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(right_drive) && $stable(left_drive))
		else $error("result word dropped or changed while stalled");

	// Drives never leave the motor range.
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> right_drive <= clf_pkg::DRIVE_W'(clf_pkg::DRIVE_MAX)
			&& left_drive <= clf_pkg::DRIVE_W'(clf_pkg::DRIVE_MAX))
		else $error("drive out of range");

	// A span error comes with both motors stopped.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && span_error |-> right_drive == '0 && left_drive == '0)
		else $error("drive nonzero on span error");

	// One item at a time: input closes right after a word is taken.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second word accepted while busy");

endmodule

bind calibrated_line_follow_steer clf_checker u_clf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.right_drive (result.right_drive),
	.left_drive  (result.left_drive),
	.span_error  (result.span_error)
);

// File: verif/calibrated_line_follow_steer_tb.sv
`timescale 1ns / 1ps

module calibrated_line_follow_steer_tb;

	// Opcode 3 has no function; the block only reports the threshold flag.
	localparam logic [clf_pkg::OP_W-1:0] OP_SPARE = 2'd3;
	localparam logic [clf_pkg::PADDR_W-1:0] BASE_POWER_ADDR = {clf_pkg::REG_BASE_POWER, 2'b00};
	localparam int GAIN = 200;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 30;

	typedef struct packed {
		logic [clf_pkg::OP_W-1:0]        opcode;
		logic [clf_pkg::SAMPLE_BITS-1:0] sample;
	} light_word_t;

	typedef struct packed {
		logic [clf_pkg::DRIVE_W-1:0] right_drive;
		logic [clf_pkg::DRIVE_W-1:0] left_drive;
		logic                        above_threshold;
		logic                        span_error;
	} drive_word_t;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [clf_pkg::PADDR_W-1:0] paddr;
	logic [clf_pkg::PDATA_W-1:0] pwdata;
	logic [clf_pkg::PDATA_W-1:0] prdata;
	logic                        pready;

	clf_cmd_if cmd_ch ();
	clf_res_if res_ch ();

	calibrated_line_follow_steer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.result  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Words waiting to be sent, and drive words expected back in order.
	light_word_t light_queue[$];
	drive_word_t drive_expected[$];
	int          words_queued = 0;
	int          words_returned = 0;
	int          mismatches = 0;
	bit          quiet_run = 1'b0;
	int          send_gap = 0;
	int          stall_left = 0;
	int          idle_cycles = 0;

	// Shadow of the calibration state and of base_power.
	logic signed [clf_pkg::ST_W-1:0] low_mark;
	logic signed [clf_pkg::ST_W-1:0] high_mark;
	logic signed [clf_pkg::ST_W-1:0] edge_mark;
	logic [clf_pkg::BASE_W-1:0]      base_shadow;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic logic [clf_pkg::DRIVE_W-1:0] clamp_power(input int v);
		if (v > clf_pkg::DRIVE_MAX)
			return clf_pkg::DRIVE_W'(clf_pkg::DRIVE_MAX);
		if (v < 0)
			return '0;
		return v[clf_pkg::DRIVE_W-1:0];
	endfunction

	// Computes the drive word of one light word and advances the calibration.
	task automatic steer_predict(input light_word_t w, output drive_word_t d);
		int s;
		int span;
		int q;
		d = '0;
		s = int'(w.sample);
		if (w.opcode == clf_pkg::OP_LATCH) begin
			edge_mark = clf_pkg::ST_W'((int'(low_mark) + int'(high_mark)) / 2);
		end else begin
			d.above_threshold = (s > int'(edge_mark));
			if (w.opcode == clf_pkg::OP_CAL) begin
				// A sample that raises the maximum never lowers the minimum.
				if (s > int'(high_mark))
					high_mark = clf_pkg::ST_W'(s);
				else if (s < int'(low_mark))
					low_mark = clf_pkg::ST_W'(s);
			end else if (w.opcode == clf_pkg::OP_FOLLOW) begin
				span = int'(high_mark) - int'(low_mark);
				if (span == 0) begin
					d.span_error = 1'b1;
				end else begin
					q = (GAIN * (int'(edge_mark) - s)) / span;
					d.right_drive = clamp_power(int'(base_shadow) + q);
					d.left_drive = clamp_power(int'(base_shadow) - q);
				end
			end
		end
	endtask

	task automatic queue_word(input logic [clf_pkg::OP_W-1:0] op, input int s);
		light_word_t w;
		w.opcode = op;
		w.sample = clf_pkg::SAMPLE_BITS'(s);
		light_queue.push_back(w);
		words_queued++;
	endtask

	// Waits until every queued word has come back.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (words_returned != words_queued);
	endtask

	task automatic write_base_power(input logic [clf_pkg::BASE_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= BASE_POWER_ADDR;
		pwdata <= clf_pkg::PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		base_shadow = value;
	endtask

	// Calibration samples spread around 600, the spread growing with the word count.
	function automatic int near_sample(input int idx);
		int spread;
		int s;
		spread = 20 + idx / 2;
		s = 600 + int'($urandom_range(0, 2 * spread)) - spread;
		if (s < 0)
			s = 0;
		if (s > 1023)
			s = 1023;
		return s;
	endfunction

	// Sender: presents one word at a time, with random bursts of gaps.
	always @(posedge clk) begin
		light_word_t w;
		if (arst_n && (!cmd_ch.valid || cmd_ch.ready)) begin
			if (send_gap > 0) begin
				send_gap--;
				cmd_ch.valid <= 1'b0;
			end else if (light_queue.size() == 0) begin
				cmd_ch.valid <= 1'b0;
			end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
				send_gap = int'($urandom_range(0, 6));
				cmd_ch.valid <= 1'b0;
			end else begin
				w = light_queue.pop_front();
				cmd_ch.valid <= 1'b1;
				cmd_ch.opcode <= w.opcode;
				cmd_ch.sample <= w.sample;
			end
		end
	end

	// Receiver: checks each drive word, predicts each accepted light word, stalls at random.
	always @(posedge clk) begin
		drive_word_t got;
		drive_word_t want;
		light_word_t w;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got.right_drive = res_ch.right_drive;
				got.left_drive = res_ch.left_drive;
				got.above_threshold = res_ch.above_threshold;
				got.span_error = res_ch.span_error;
				if (drive_expected.size() == 0) begin
					report_mismatch("unexpected drive word, right_drive",
						int'(got.right_drive), 0);
				end else begin
					want = drive_expected.pop_front();
					words_returned++;
					if (got.right_drive !== want.right_drive)
						report_mismatch("right_drive", int'(got.right_drive),
							int'(want.right_drive));
					if (got.left_drive !== want.left_drive)
						report_mismatch("left_drive", int'(got.left_drive),
							int'(want.left_drive));
					if (got.above_threshold !== want.above_threshold)
						report_mismatch("above_threshold", int'(got.above_threshold),
							int'(want.above_threshold));
					if (got.span_error !== want.span_error)
						report_mismatch("span_error", int'(got.span_error),
							int'(want.span_error));
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				w.opcode = cmd_ch.opcode;
				w.sample = cmd_ch.sample;
				steer_predict(w, want);
				drive_expected.push_back(want);
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
				stall_left = int'($urandom_range(0, 6));
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run after too long without any handshake.
	always @(posedge clk) begin
		if (!arst_n || psel || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int idx;
		int pick;
		int s;
		logic [clf_pkg::OP_W-1:0] op;
		logic [clf_pkg::BASE_W-1:0] phase_power[4];

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = clf_pkg::OP_CAL;
		cmd_ch.sample = '0;
		res_ch.ready = 1'b0;
		low_mark = clf_pkg::ST_W'(clf_pkg::LOW_RESET);
		high_mark = clf_pkg::ST_W'(clf_pkg::HIGH_RESET);
		edge_mark = '0;
		base_shadow = clf_pkg::BASE_W'(clf_pkg::BASE_RESET);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Never calibrated: the span is negative and the division runs signed.
		queue_word(clf_pkg::OP_FOLLOW, 0);
		queue_word(clf_pkg::OP_FOLLOW, 1023);
		queue_word(OP_SPARE, 1023);
		queue_word(clf_pkg::OP_LATCH, 1023);
		queue_word(clf_pkg::OP_FOLLOW, 600);
		// Equal maximum and minimum give a zero span.
		queue_word(clf_pkg::OP_CAL, 600);
		queue_word(clf_pkg::OP_CAL, 600);
		queue_word(clf_pkg::OP_FOLLOW, 0);
		queue_word(clf_pkg::OP_FOLLOW, 1023);
		queue_word(clf_pkg::OP_LATCH, 0);
		// A narrow calibrated range, then steering across it.
		queue_word(clf_pkg::OP_CAL, 610);
		queue_word(clf_pkg::OP_CAL, 590);
		queue_word(clf_pkg::OP_CAL, 600);
		queue_word(clf_pkg::OP_LATCH, 0);
		queue_word(clf_pkg::OP_FOLLOW, 0);
		queue_word(clf_pkg::OP_FOLLOW, 1023);
		queue_word(clf_pkg::OP_FOLLOW, 600);
		queue_word(clf_pkg::OP_FOLLOW, 601);
		queue_word(clf_pkg::OP_FOLLOW, 599);
		queue_word(OP_SPARE, 0);
		wait_drained();

		// Random phases, each under its own base power; each phase drains before the next.
		phase_power[0] = '0;
		phase_power[1] = '1;
		phase_power[2] = clf_pkg::BASE_W'($urandom_range(1, clf_pkg::DRIVE_MAX - 1));
		phase_power[3] = clf_pkg::BASE_W'(clf_pkg::DRIVE_MAX);
		idx = 0;
		for (int ph = 0; ph < 4; ph++) begin
			write_base_power(phase_power[ph]);
			if (ph == 3)
				quiet_run = 1'b1;
			for (int n = 0; n < ((ph == 3) ? 300 : 450); n++) begin
				pick = int'($urandom_range(0, 19));
				if (pick < 5)
					op = clf_pkg::OP_CAL;
				else if (pick < 7)
					op = clf_pkg::OP_LATCH;
				else if (pick < 18)
					op = clf_pkg::OP_FOLLOW;
				else
					op = OP_SPARE;
				if (op == clf_pkg::OP_CAL || $urandom_range(0, 1) == 0)
					s = near_sample(idx);
				else
					s = int'($urandom_range(0, 1023));
				queue_word(op, s);
				idx++;
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (drive_expected.size() != 0)
			report_mismatch("drive words never returned", 0, drive_expected.size());
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: calibrated_line_follow_steer.f
hdl/clf_pkg.sv
hdl/clf_if.sv
hdl/calibrated_line_follow_steer.sv
hdl/clf_checker.sv
verif/calibrated_line_follow_steer_tb.sv
